// ===== rtl/core/assert_macros.svh =====
// Shared assertion helpers for the byte engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define A_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define A_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

  // request codes on req_type
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_GAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd2;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
  localparam logic [15:0] STOP_GAP_RST    = 16'd10;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [2:0] {
    K_TICK,
    K_START,
    K_STOP,
    K_WRITE,
    K_READ,
    K_NOP
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_A    = 4'd1,
    PH_ST_B    = 4'd2,
    PH_ST_C    = 4'd3,
    PH_ST_D    = 4'd4,
    PH_SP_A    = 4'd5,
    PH_SP_B    = 4'd6,
    PH_SP_C    = 4'd7,
    PH_WR_LOW  = 4'd8,
    PH_WR_HIGH = 4'd9,
    PH_POLL    = 4'd10,
    PH_RD_LOW  = 4'd11,
    PH_RD_HIGH = 4'd12
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       mack;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_ok;
    logic       rejected;
  } result_t;

endpackage

// ===== rtl/core/i2cm_front.sv =====
`include "assert_macros.svh"

module i2cm_front import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [2:0] req_type,
  input  logic [7:0] data_byte,
  input  logic       master_ack,
  input  logic       sda_sample,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_take
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  item_t      decoded;

  always_comb begin
    decoded.data = data_byte;
    decoded.mack = master_ack;
    decoded.sda  = sda_sample;
    case (req_type)
      REQ_TICK:  decoded.kind = K_TICK;
      REQ_START: decoded.kind = K_START;
      REQ_STOP:  decoded.kind = K_STOP;
      REQ_WRITE: decoded.kind = K_WRITE;
      REQ_READ:  decoded.kind = K_READ;
      default:   decoded.kind = K_NOP;
    endcase
  end

  assign full       = (count == 2'd2);
  assign accept     = push && !full;
  assign item_valid = (count != 2'd0);
  assign item       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      slot[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (item_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, accept} - {1'b0, item_take};
    end
  end

  `A_IMPLY(a_front_cnt, clk, rst, 1'b1, count <= 2'd2)
  `A_NEXT(a_front_fill, clk, rst, accept && !item_take && count == 2'd1, full)

endmodule

// ===== rtl/core/i2cm_engine.sv =====
`include "assert_macros.svh"

module i2cm_engine import i2cm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 item_valid,
  input  item_t                item,
  output logic                 item_take,
  input  logic                 res_full,
  output logic                 res_push,
  output result_t              res
);

  logic [15:0] half_period;
  logic [15:0] stop_gap;
  logic [7:0]  ack_timeout;

  phase_t      phase, phase_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] delay_count, delay_count_next;
  logic [7:0]  poll_count, poll_count_next;
  logic        scl_drive, scl_drive_next;
  logic        sda_drive, sda_drive_next;
  logic        ack_flag, ack_flag_next;
  logic [7:0]  rx_reg, rx_reg_next;
  logic        ack_latch, ack_latch_next;

  logic        expire;

  assign item_take = item_valid && !res_full;
  assign res_push  = item_take;
  assign expire    = (delay_count <= 16'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RST;
      stop_gap    <= STOP_GAP_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HALF_PERIOD: half_period <= cfg_data;
        CFG_STOP_GAP:    stop_gap    <= cfg_data;
        CFG_ACK_TIMEOUT: ack_timeout <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    delay_count_next = delay_count;
    poll_count_next  = poll_count;
    scl_drive_next   = scl_drive;
    sda_drive_next   = sda_drive;
    ack_flag_next    = ack_flag;
    rx_reg_next      = rx_reg;
    ack_latch_next   = ack_latch;
    case (item.kind)
      K_TICK: begin
        if (phase == PH_POLL) begin
          if (!item.sda) begin
            scl_drive_next = 1'b1;
            ack_flag_next  = 1'b1;
            phase_next     = PH_IDLE;
          end else if (poll_count >= ack_timeout) begin
            ack_flag_next    = 1'b0;
            scl_drive_next   = 1'b1;
            sda_drive_next   = 1'b1;
            phase_next       = PH_SP_A;
            delay_count_next = half_period;
          end else begin
            poll_count_next = poll_count + 8'd1;
          end
        end else if (phase != PH_IDLE) begin
          if (!expire) begin
            delay_count_next = delay_count - 16'd1;
          end else begin
            delay_count_next = 16'd0;
            case (phase)
              PH_ST_A: begin
                scl_drive_next   = 1'b0;
                phase_next       = PH_ST_B;
                delay_count_next = half_period;
              end
              PH_ST_B: begin
                sda_drive_next   = 1'b1;
                phase_next       = PH_ST_C;
                delay_count_next = half_period;
              end
              PH_ST_C: begin
                scl_drive_next   = 1'b1;
                phase_next       = PH_ST_D;
                delay_count_next = half_period;
              end
              PH_SP_A: begin
                scl_drive_next   = 1'b0;
                phase_next       = PH_SP_B;
                delay_count_next = stop_gap;
              end
              PH_SP_B: begin
                sda_drive_next   = 1'b0;
                phase_next       = PH_SP_C;
                delay_count_next = half_period;
              end
              PH_ST_D, PH_SP_C: phase_next = PH_IDLE;
              PH_WR_LOW, PH_RD_LOW: begin
                scl_drive_next   = 1'b0;
                phase_next       = (phase == PH_WR_LOW) ? PH_WR_HIGH : PH_RD_HIGH;
                delay_count_next = half_period;
              end
              PH_WR_HIGH: begin
                if (bit_count >= BITS_PER_BYTE) begin
                  poll_count_next = 8'd0;
                  phase_next      = PH_POLL;
                end else begin
                  shift_reg_next   = {shift_reg[6:0], 1'b0};
                  bit_count_next   = bit_count + 4'd1;
                  scl_drive_next   = 1'b1;
                  sda_drive_next   = (bit_count_next >= BITS_PER_BYTE) ? 1'b0
                                                                       : ~shift_reg[6];
                  phase_next       = PH_WR_LOW;
                  delay_count_next = half_period;
                end
              end
              PH_RD_HIGH: begin
                if (bit_count >= BITS_PER_BYTE) begin
                  scl_drive_next = 1'b1;
                  phase_next     = PH_IDLE;
                end else begin
                  shift_reg_next = {shift_reg[6:0], item.sda};
                  bit_count_next = bit_count + 4'd1;
                  if (bit_count_next == BITS_PER_BYTE) rx_reg_next = shift_reg_next;
                  scl_drive_next = 1'b1;
                  if (bit_count_next >= BITS_PER_BYTE) sda_drive_next = ack_latch;
                  phase_next       = PH_RD_LOW;
                  delay_count_next = half_period;
                end
              end
              default: phase_next = PH_IDLE;
            endcase
          end
        end
      end
      K_START, K_STOP, K_WRITE, K_READ: begin
        if (phase == PH_IDLE) begin
          bit_count_next   = 4'd0;
          delay_count_next = half_period;
          case (item.kind)
            K_START: begin
              sda_drive_next = 1'b0;
              phase_next     = PH_ST_A;
            end
            K_STOP: begin
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b1;
              phase_next     = PH_SP_A;
            end
            K_WRITE: begin
              shift_reg_next = item.data;
              scl_drive_next = 1'b1;
              sda_drive_next = ~item.data[7];
              phase_next     = PH_WR_LOW;
            end
            default: begin
              ack_latch_next = item.mack;
              shift_reg_next = 8'd0;
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b0;
              phase_next     = PH_RD_LOW;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // result outputs
  always_comb begin
    res.scl_low  = scl_drive_next;
    res.sda_low  = sda_drive_next;
    res.busy     = (phase_next != PH_IDLE);
    res.rx_byte  = rx_reg_next;
    res.ack_ok   = ack_flag_next;
    res.rejected = (item.kind inside {K_START, K_STOP, K_WRITE, K_READ}) &&
                   (phase != PH_IDLE);
    res.done     = 1'b0;
    if (item.kind == K_TICK) begin
      if (phase == PH_POLL) begin
        res.done = !item.sda;
      end else if (expire) begin
        res.done = (phase inside {PH_ST_D, PH_SP_C}) ||
                   (phase == PH_RD_HIGH && bit_count >= BITS_PER_BYTE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= 4'd0;
      shift_reg   <= 8'd0;
      delay_count <= 16'd0;
      poll_count  <= 8'd0;
      scl_drive   <= 1'b1;
      sda_drive   <= 1'b1;
      ack_flag    <= 1'b0;
      rx_reg      <= 8'd0;
      ack_latch   <= 1'b0;
    end else if (item_take) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      delay_count <= delay_count_next;
      poll_count  <= poll_count_next;
      scl_drive   <= scl_drive_next;
      sda_drive   <= sda_drive_next;
      ack_flag    <= ack_flag_next;
      rx_reg      <= rx_reg_next;
      ack_latch   <= ack_latch_next;
    end
  end

  `A_IMPLY(a_bit_cnt, clk, rst, 1'b1, bit_count <= BITS_PER_BYTE)
  `A_IMPLY(a_poll_cnt, clk, rst, phase == PH_POLL, poll_count <= ack_timeout)
  `A_NEXT(a_cmd_busy, clk, rst, item_take && phase == PH_IDLE && item.kind == K_WRITE,
          phase == PH_WR_LOW)
  `A_IMPLY(a_done_idle, clk, rst, res_push && res.done, !res.busy && !res.rejected)

endmodule

// ===== rtl/core/i2cm_res_q.sv =====
`include "assert_macros.svh"

module i2cm_res_q import i2cm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res,
  output logic    res_full,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       take;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign take     = pop && !empty;
  assign head     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      slot[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, res_push} - {1'b0, take};
    end
  end

  `A_IMPLY(a_res_no_ovf, clk, rst, res_full, !res_push)
  `A_NEXT(a_res_avail, clk, rst, res_push, !empty)

endmodule

// ===== rtl/core/i2c_master_byte_engine_unit.sv =====
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------------
// items    | push / full               | req_type, data_byte, master_ack, sda_sample
// results  | empty / pop               | scl_low, sda_low, busy_res, done_res, rx_byte,
//          |                           | ack_ok, cmd_rejected
// config   | cfg_we (no wait)          | cfg_index, cfg_data
//
// Sustained rate is one item per clock while the result queue is not full; every item yields exactly one result.
// A result can be popped once its item has been registered in the item queue and then
// passed through the phase engine into the result queue.
// Synchronous active-high rst empties both queues, releases nothing (both lines
// driven low) and loads the configuration defaults.
// When the result queue fills the engine holds, and the two-entry item queue
// then raises full; either side may stall without losing a transaction.

module i2c_master_byte_engine_unit import i2cm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // item channel
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           req_type,
  input  logic [7:0]           data_byte,
  input  logic                 master_ack,
  input  logic                 sda_sample,
  // result channel
  output logic                 empty,
  input  logic                 pop,
  output logic                 scl_low,
  output logic                 sda_low,
  output logic                 busy_res,
  output logic                 done_res,
  output logic [7:0]           rx_byte,
  output logic                 ack_ok,
  output logic                 cmd_rejected,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    res_full;
  logic    res_push;
  result_t res;
  result_t head;

  // front: classify req_type and buffer the transaction
  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .master_ack (master_ack),
    .sda_sample (sda_sample),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // back: bus phase sequencer, one item per clock while results drain
  i2cm_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  // result queue parts the engine from the consumer
  i2cm_res_q u_res_q (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign scl_low      = head.scl_low;
  assign sda_low      = head.sda_low;
  assign busy_res     = head.busy;
  assign done_res     = head.done;
  assign rx_byte      = head.rx_byte;
  assign ack_ok       = head.ack_ok;
  assign cmd_rejected = head.rejected;

endmodule
